>>> src/sfm_pkg.sv
package sfm_pkg;

  localparam int VALUE_COUNT   = 4;
  localparam int COUNTER_WIDTH = 32;
  localparam int NUM_COUNTERS  = 13;
  localparam int CNT_IDX_W     = 4;
  localparam int CFG_IDX_W     = 2;
  localparam int QDEPTH        = 2;
  localparam int QPTR_W        = $clog2(QDEPTH);
  localparam int QCNT_W        = $clog2(QDEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_SOURCE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE         = CFG_IDX_W'(1);

  localparam logic [31:0] EXPECTED_SOURCE_RST = 32'd1;
  localparam logic [31:0] MAX_AGE_RST         = 32'd250000;

  typedef enum logic [2:0] {
    OP_PUBLISH  = 3'd0,
    OP_LOSS     = 3'd1,
    OP_ERROR    = 3'd2,
    OP_TIMEOUT  = 3'd3,
    OP_POLL     = 3'd4,
    OP_CONSUME  = 3'd5,
    OP_CLEAR    = 3'd6,
    OP_READ     = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED    = 3'd0,
    ST_BAD_ID      = 3'd1,
    ST_BAD_VALUE   = 3'd2,
    ST_DELAYED     = 3'd3,
    ST_STALE       = 3'd4,
    ST_ORDER       = 3'd5,
    ST_NOT_PUBLISH = 3'd6
  } status_t;

  typedef enum logic [CNT_IDX_W-1:0] {
    C_ACCEPTED = 4'd0,
    C_IDENTITY = 4'd1,
    C_NONFINITE = 4'd2,
    C_DELAYED  = 4'd3,
    C_STALE    = 4'd4,
    C_ORDER    = 4'd5,
    C_PRESSURE = 4'd6,
    C_RECOVER  = 4'd7,
    C_LOSS     = 4'd8,
    C_ERRORS   = 4'd9,
    C_TIMEOUTS = 4'd10,
    C_AGE      = 4'd11,
    C_FALLBACK = 4'd12
  } cnt_idx_t;

  typedef logic [COUNTER_WIDTH-1:0] cnt_t;

  // Classified item as it passes from the front to the back.
  typedef struct packed {
    op_t                  op;
    status_t              pre;
    logic [31:0]          seq;
    logic [63:0]          av;
    logic [63:0]          now;
    logic [CNT_IDX_W-1:0] sel;
  } cmd_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

>>> src/sfm_if.sv
interface sfm_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [31:0] producer_id;
  logic [31:0] sequence_req;
  logic [63:0] event_time;
  logic [63:0] available_time;
  logic [63:0] now_time;
  logic [31:0] value_0;
  logic [31:0] value_1;
  logic [31:0] value_2;
  logic [31:0] value_3;
  logic [3:0]  counter_select;

  modport source (
    output valid, op, producer_id, sequence_req, event_time, available_time, now_time,
    output value_0, value_1, value_2, value_3, counter_select,
    input  ready
  );
  modport sink (
    input  valid, op, producer_id, sequence_req, event_time, available_time, now_time,
    input  value_0, value_1, value_2, value_3, counter_select,
    output ready
  );
endinterface

interface sfm_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        is_valid;
  logic        is_pending;
  logic [31:0] counter_value;

  modport source (output valid, status, is_valid, is_pending, counter_value, input ready);
  modport sink (input valid, status, is_valid, is_pending, counter_value, output ready);
endinterface

interface sfm_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> src/sfm_front.sv
module sfm_front (
  sfm_in_if.sink         in_ch,
  input  logic [31:0]    expected_source,
  input  logic [31:0]    max_age,
  input  sfm_pkg::q_stat_t q_stat,
  output logic           push,
  output sfm_pkg::cmd_t  cmd
);
  import sfm_pkg::*;

  logic [31:0] vals [4];
  logic [3:0]  bad;
  logic        any_bad;
  logic        delayed;
  logic [63:0] age;
  logic        stale;

  assign vals[0] = in_ch.value_0;
  assign vals[1] = in_ch.value_1;
  assign vals[2] = in_ch.value_2;
  assign vals[3] = in_ch.value_3;

  // A value fails when its exponent is all ones or when it is negative and non-zero.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (i < VALUE_COUNT) begin
        bad[i] = (vals[i][30:23] == 8'hFF) || (vals[i][31] && (vals[i][30:0] != 31'd0));
      end else begin
        bad[i] = 1'b0;
      end
    end
  end

  assign any_bad = |bad;
  assign delayed = (in_ch.available_time > in_ch.now_time) ||
                   (in_ch.event_time > in_ch.available_time);
  assign age     = in_ch.now_time - in_ch.available_time;
  assign stale   = age > {32'd0, max_age};

  assign in_ch.ready = !q_stat.full;
  assign push        = in_ch.valid && !q_stat.full;

  always_comb begin
    cmd.op  = op_t'(in_ch.op);
    cmd.seq = in_ch.sequence_req;
    cmd.av  = in_ch.available_time;
    cmd.now = in_ch.now_time;
    cmd.sel = in_ch.counter_select;
    if (op_t'(in_ch.op) != OP_PUBLISH) begin
      cmd.pre = ST_NOT_PUBLISH;
    end else if (in_ch.producer_id != expected_source) begin
      cmd.pre = ST_BAD_ID;
    end else if (any_bad) begin
      cmd.pre = ST_BAD_VALUE;
    end else if (delayed) begin
      cmd.pre = ST_DELAYED;
    end else if (stale) begin
      cmd.pre = ST_STALE;
    end else begin
      cmd.pre = ST_ACCEPTED;
    end
  end

endmodule

>>> src/sfm_queue.sv
module sfm_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  sfm_pkg::q_ctrl_t ctrl,
  input  sfm_pkg::cmd_t    wr_data,
  output sfm_pkg::cmd_t    rd_data,
  output sfm_pkg::q_stat_t stat
);
  import sfm_pkg::*;

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign rd_data    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (ctrl.push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (ctrl.pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (ctrl.push && !ctrl.pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (!ctrl.push && ctrl.pop) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> src/sfm_back.sv
module sfm_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [31:0]      max_age,
  input  sfm_pkg::q_stat_t q_stat,
  input  sfm_pkg::cmd_t    cmd,
  output logic             pop,
  sfm_out_if.source        out_ch
);
  import sfm_pkg::*;

  logic        valid_r, valid_nxt;
  logic        pending_r, pending_nxt;
  logic        ever_r, ever_nxt;
  logic [31:0] last_seq_r, last_seq_nxt;
  logic [63:0] last_av_r, last_av_nxt;
  cnt_t        cnt_r [NUM_COUNTERS];
  cnt_t        cnt_nxt [NUM_COUNTERS];
  logic [NUM_COUNTERS-1:0] inc;
  logic        clr;
  logic [63:0] poll_age;

  logic        ov_r, ov_nxt;
  status_t     status_r, status_nxt;
  logic [31:0] cval_r, cval_nxt;

  assign pop      = !q_stat.empty && (!ov_r || out_ch.ready);
  assign poll_age = cmd.now - last_av_r;

  always_comb begin
    valid_nxt    = valid_r;
    pending_nxt  = pending_r;
    ever_nxt     = ever_r;
    last_seq_nxt = last_seq_r;
    last_av_nxt  = last_av_r;
    inc          = '0;
    clr          = 1'b0;
    status_nxt   = status_r;
    cval_nxt     = cval_r;
    ov_nxt       = ov_r && !out_ch.ready;

    if (pop) begin
      ov_nxt     = 1'b1;
      status_nxt = cmd.pre;
      cval_nxt   = '0;
      case (cmd.op)
        OP_PUBLISH: begin
          if (cmd.pre == ST_ACCEPTED && ever_r && cmd.seq <= last_seq_r) begin
            status_nxt = ST_ORDER;
          end
          case (status_nxt)
            ST_ACCEPTED: begin
              inc[C_ACCEPTED] = 1'b1;
              inc[C_PRESSURE] = pending_r;
              inc[C_RECOVER]  = ever_r && !valid_r;
              last_seq_nxt    = cmd.seq;
              last_av_nxt     = cmd.av;
              valid_nxt       = 1'b1;
              pending_nxt     = 1'b1;
              ever_nxt        = 1'b1;
            end
            ST_BAD_ID:    inc[C_IDENTITY]  = 1'b1;
            ST_BAD_VALUE: inc[C_NONFINITE] = 1'b1;
            ST_DELAYED:   inc[C_DELAYED]   = 1'b1;
            ST_STALE:     inc[C_STALE]     = 1'b1;
            ST_ORDER:     inc[C_ORDER]     = 1'b1;
            default:      inc              = '0;
          endcase
          if (status_nxt != ST_ACCEPTED) begin
            valid_nxt   = 1'b0;
            pending_nxt = 1'b0;
          end
        end
        OP_LOSS, OP_ERROR, OP_TIMEOUT: begin
          if (cmd.op == OP_LOSS) begin
            inc[C_LOSS] = 1'b1;
          end else if (cmd.op == OP_ERROR) begin
            inc[C_ERRORS] = 1'b1;
          end else begin
            inc[C_TIMEOUTS] = 1'b1;
          end
          valid_nxt   = 1'b0;
          pending_nxt = 1'b0;
        end
        OP_POLL: begin
          if (valid_r && poll_age > {32'd0, max_age}) begin
            inc[C_AGE]  = 1'b1;
            valid_nxt   = 1'b0;
            pending_nxt = 1'b0;
          end
        end
        OP_CONSUME: begin
          inc[C_FALLBACK] = !valid_r;
          pending_nxt     = 1'b0;
        end
        OP_CLEAR: begin
          clr          = 1'b1;
          valid_nxt    = 1'b0;
          pending_nxt  = 1'b0;
          ever_nxt     = 1'b0;
          last_seq_nxt = '0;
          last_av_nxt  = '0;
        end
        OP_READ: begin
          if (cmd.sel < CNT_IDX_W'(NUM_COUNTERS)) begin
            cval_nxt = 32'(cnt_r[cmd.sel]);
          end
        end
        default: ov_nxt = 1'b1;
      endcase
    end

    for (int i = 0; i < NUM_COUNTERS; i++) begin
      cnt_nxt[i] = clr ? '0 : cnt_r[i] + cnt_t'(inc[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      pending_r  <= 1'b0;
      ever_r     <= 1'b0;
      last_seq_r <= '0;
      last_av_r  <= '0;
      ov_r       <= 1'b0;
      for (int i = 0; i < NUM_COUNTERS; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      valid_r    <= valid_nxt;
      pending_r  <= pending_nxt;
      ever_r     <= ever_nxt;
      last_seq_r <= last_seq_nxt;
      last_av_r  <= last_av_nxt;
      ov_r       <= ov_nxt;
      for (int i = 0; i < NUM_COUNTERS; i++) begin
        cnt_r[i] <= cnt_nxt[i];
      end
    end
  end

  logic out_valid_flag_r, out_pending_flag_r;

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    cval_r   <= cval_nxt;
    if (pop) begin
      out_valid_flag_r   <= valid_nxt;
      out_pending_flag_r <= pending_nxt;
    end
  end

  assign out_ch.valid         = ov_r;
  assign out_ch.status        = status_r;
  assign out_ch.is_valid      = out_valid_flag_r;
  assign out_ch.is_pending    = out_pending_flag_r;
  assign out_ch.counter_value = cval_r;

endmodule

>>> src/sample_freshness_monitor.sv
// Channel  | Direction | Handshake     | Carries
// in_ch    | in        | valid / ready | op, identity, sequence, times, values, counter select
// out_ch   | out       | valid / ready | status, valid and pending flags, counter value
// cfg_ch   | in        | valid / ready | register index and write data, always ready
//
// One item is accepted per cycle while the queue is not full.
// The front classifies the stateless checks and pushes into a two-entry queue, and the
// back applies the state and registers the result in a single output register.
// Reset clears the flags, sequence, time and all counters, and restores the registers.
// A stalled output holds its result; the queue takes items until it is full.
module sample_freshness_monitor (
  input  logic      clk,
  input  logic      rst_n,
  sfm_in_if.sink    in_ch,
  sfm_out_if.source out_ch,
  sfm_cfg_if.sink   cfg_ch
);
  import sfm_pkg::*;

  logic [31:0] expected_source_r;
  logic [31:0] max_age_r;
  logic        push;
  logic        pop;
  cmd_t        wr_cmd;
  cmd_t        rd_cmd;
  q_ctrl_t     q_ctrl;
  q_stat_t     q_stat;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_source_r <= EXPECTED_SOURCE_RST;
      max_age_r         <= MAX_AGE_RST;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == CFG_EXPECTED_SOURCE) begin
        expected_source_r <= cfg_ch.data;
      end else if (cfg_ch.index == CFG_MAX_AGE) begin
        max_age_r <= cfg_ch.data;
      end
    end
  end

  assign q_ctrl.push = push;
  assign q_ctrl.pop  = pop;

  sfm_front u_front (
    .in_ch           (in_ch),
    .expected_source (expected_source_r),
    .max_age         (max_age_r),
    .q_stat          (q_stat),
    .push            (push),
    .cmd             (wr_cmd)
  );

  sfm_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (q_ctrl),
    .wr_data (wr_cmd),
    .rd_data (rd_cmd),
    .stat    (q_stat)
  );

  sfm_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .max_age (max_age_r),
    .q_stat  (q_stat),
    .cmd     (rd_cmd),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

>>> dv/sample_freshness_monitor_test.sv
`timescale 1ns / 1ps

module sample_freshness_monitor_test;
  import sfm_pkg::*;

  localparam int                   SETTLE_CYCLES   = 8;
  localparam int                   STALL_LIMIT     = 2000;
  localparam int                   HOLD_CYCLES     = 80;
  localparam int                   ITEMS_PER_PHASE = 232;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE       = CFG_IDX_W'(3);
  localparam logic [CNT_IDX_W-1:0] SEL_BEYOND      = CNT_IDX_W'(15);

  typedef struct packed {
    op_t                  op;
    logic [31:0]          source;
    logic [31:0]          seq;
    logic [63:0]          ev;
    logic [63:0]          av;
    logic [63:0]          now;
    logic [3:0][31:0]     vals;
    logic [CNT_IDX_W-1:0] sel;
  } sample_t;

  typedef struct packed {
    status_t status;
    logic    fresh;
    logic    pending;
    cnt_t    count;
  } verdict_t;

  logic clk;
  logic rst_n;

  sfm_in_if  in_ch ();
  sfm_out_if out_ch ();
  sfm_cfg_if cfg_ch ();

  sample_freshness_monitor dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Our own copy of the monitor's registers and state.
  logic [31:0] reg_source;
  logic [31:0] reg_age;
  logic        mon_valid;
  logic        mon_pending;
  logic        mon_seen;
  logic [31:0] mon_seq;
  logic [63:0] mon_av;
  cnt_t        mon_counts [NUM_COUNTERS];

  sample_t     sample_q [$];
  verdict_t    verdict_q [$];
  sample_t     bus_item;
  logic        item_on_bus;
  int          mismatch_count;
  int          idle_pct;
  int          stall_pct;
  int unsigned hold_token;
  int unsigned hold_seen;
  int unsigned hold_left;
  int unsigned quiet_cycles;
  logic [31:0] gen_seq;
  logic [63:0] gen_clock;

  always #10 clk = ~clk;

  function automatic void forget_all();
    mon_valid   = 1'b0;
    mon_pending = 1'b0;
    mon_seen    = 1'b0;
    mon_seq     = '0;
    mon_av      = '0;
    for (int i = 0; i < NUM_COUNTERS; i++) mon_counts[i] = '0;
  endfunction

  function automatic void tally(cnt_idx_t which);
    mon_counts[which] = mon_counts[which] + cnt_t'(1);
  endfunction

  function automatic void reject(cnt_idx_t which);
    tally(which);
    mon_valid   = 1'b0;
    mon_pending = 1'b0;
  endfunction

  function automatic verdict_t predict_verdict(sample_t it);
    verdict_t v;
    logic     bad_value;
    v.status  = ST_NOT_PUBLISH;
    v.count   = '0;
    bad_value = 1'b0;
    case (it.op)
      OP_PUBLISH: begin
        for (int i = 0; i < VALUE_COUNT && i < 4; i++) begin
          bad_value |= (it.vals[i][30:23] == 8'hFF) || (it.vals[i][31] && it.vals[i][30:0] != '0);
        end
        if (it.source != reg_source) begin
          reject(C_IDENTITY);
          v.status = ST_BAD_ID;
        end else if (bad_value) begin
          reject(C_NONFINITE);
          v.status = ST_BAD_VALUE;
        end else if (it.av > it.now || it.ev > it.av) begin
          reject(C_DELAYED);
          v.status = ST_DELAYED;
        end else if (it.now - it.av > {32'd0, reg_age}) begin
          reject(C_STALE);
          v.status = ST_STALE;
        end else if (mon_seen && it.seq <= mon_seq) begin
          reject(C_ORDER);
          v.status = ST_ORDER;
        end else begin
          if (mon_pending) tally(C_PRESSURE);
          if (mon_seen && !mon_valid) tally(C_RECOVER);
          mon_seq     = it.seq;
          mon_av      = it.av;
          mon_valid   = 1'b1;
          mon_pending = 1'b1;
          mon_seen    = 1'b1;
          tally(C_ACCEPTED);
          v.status = ST_ACCEPTED;
        end
      end
      OP_LOSS:    reject(C_LOSS);
      OP_ERROR:   reject(C_ERRORS);
      OP_TIMEOUT: reject(C_TIMEOUTS);
      OP_POLL: begin
        if (mon_valid && (it.now - mon_av) > {32'd0, reg_age}) reject(C_AGE);
      end
      OP_CONSUME: begin
        if (!mon_valid) tally(C_FALLBACK);
        mon_pending = 1'b0;
      end
      OP_CLEAR: forget_all();
      default: begin
        if (it.sel < CNT_IDX_W'(NUM_COUNTERS)) v.count = mon_counts[it.sel];
      end
    endcase
    v.fresh   = mon_valid;
    v.pending = mon_pending;
    return v;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic sample_t noise_item();
    sample_t it;
    it.op     = op_t'($urandom_range(0, 7));
    it.source = $urandom;
    it.seq    = $urandom;
    it.ev     = rand64();
    it.av     = rand64();
    it.now    = rand64();
    for (int i = 0; i < 4; i++) it.vals[i] = $urandom;
    it.sel    = CNT_IDX_W'($urandom);
    return it;
  endfunction

  function automatic sample_t command(op_t op, logic [CNT_IDX_W-1:0] sel, logic [63:0] now);
    sample_t it;
    it     = '0;
    it.op  = op;
    it.sel = sel;
    it.now = now;
    return it;
  endfunction

  function automatic sample_t publish_at(logic [31:0] seq, logic [63:0] ev, logic [63:0] av,
                                         logic [63:0] now);
    sample_t it;
    it        = command(OP_PUBLISH, '0, now);
    it.source = reg_source;
    it.seq    = seq;
    it.ev     = ev;
    it.av     = av;
    return it;
  endfunction

  function automatic logic [31:0] finite_value();
    logic [31:0] bits;
    bits = $urandom;
    case ($urandom_range(0, 7))
      0: bits = 32'h0000_0000;
      1: bits = 32'h8000_0000;
      default: begin
        bits[31] = 1'b0;
        if (bits[30:23] == 8'hFF) bits[30] = 1'b0;
      end
    endcase
    return bits;
  endfunction

  // Mostly well-formed publishes that move time and sequence forward, with a share of
  // broken publishes, status events, polls, consumes, reads, clears and raw noise.
  function automatic sample_t random_item();
    sample_t     it;
    logic [63:0] lag;
    logic [31:0] bad_bits;
    int          pick;
    int          k;
    pick = $urandom_range(0, 99);
    it   = noise_item();
    if (pick < 65) begin
      gen_seq   += $urandom_range(1, 4);
      gen_clock += 64'($urandom_range(1, 5000));
      lag = 64'($urandom_range(0, reg_age));
      if ($urandom_range(0, 9) == 0) lag = {32'd0, reg_age};
      it = publish_at(gen_seq, gen_clock - lag - 64'($urandom_range(0, 1000)), gen_clock - lag,
                      gen_clock);
      for (int i = 0; i < 4; i++) it.vals[i] = finite_value();
      it.sel = CNT_IDX_W'($urandom);
      if (pick >= 55) begin
        case ($urandom_range(0, 4))
          0: it.source = reg_source ^ ($urandom | 32'd1);
          1: begin
            k = $urandom_range(0, 3);
            bad_bits = $urandom;
            if ($urandom_range(0, 1)) begin
              bad_bits[30:23] = 8'hFF;
            end else begin
              bad_bits[31] = 1'b1;
              if (bad_bits[30:0] == '0) bad_bits[0] = 1'b1;
            end
            it.vals[k] = bad_bits;
          end
          2: begin
            if ($urandom_range(0, 1)) it.av = it.now + 64'($urandom_range(1, 1000));
            else it.ev = it.av + 64'($urandom_range(1, 1000));
          end
          3: begin
            it.av = it.now - {32'd0, reg_age} - 64'($urandom_range(1, 1000));
            it.ev = it.av - 64'($urandom_range(0, 1000));
          end
          default: it.seq = gen_seq - $urandom_range(4, 40);
        endcase
      end
    end else if (pick < 75) begin
      it.op  = OP_POLL;
      it.now = gen_clock + (($urandom_range(0, 3) == 0) ?
               {32'd0, reg_age} + 64'($urandom_range(1, 100000)) :
               64'($urandom_range(0, 1000)));
    end else if (pick < 82) begin
      it.op = OP_CONSUME;
    end else if (pick < 87) begin
      it.op = op_t'($urandom_range(int'(OP_LOSS), int'(OP_TIMEOUT)));
    end else if (pick < 94) begin
      it.op = OP_READ;
    end else if (pick < 95) begin
      it.op = OP_CLEAR;
    end
    return it;
  endfunction

  function automatic void flag_field(string field, logic [63:0] expv, logic [63:0] got);
    mismatch_count++;
    $error("%s: expected %0h, got %0h", field, expv, got);
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_EXPECTED_SOURCE: reg_source = val;
      CFG_MAX_AGE:         reg_age    = val;
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (sample_q.size() != 0 || verdict_q.size() != 0 || item_on_bus) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Sender: takes the next pending item when the bus is free and it is not idling.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      item_on_bus = 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        verdict_q.push_back(predict_verdict(bus_item));
        item_on_bus = 1'b0;
      end
      if (!item_on_bus) begin
        if (sample_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          bus_item    = sample_q.pop_front();
          item_on_bus = 1'b1;
          in_ch.op             <= bus_item.op;
          in_ch.producer_id    <= bus_item.source;
          in_ch.sequence_req   <= bus_item.seq;
          in_ch.event_time     <= bus_item.ev;
          in_ch.available_time <= bus_item.av;
          in_ch.now_time       <= bus_item.now;
          in_ch.value_0        <= bus_item.vals[0];
          in_ch.value_1        <= bus_item.vals[1];
          in_ch.value_2        <= bus_item.vals[2];
          in_ch.value_3        <= bus_item.vals[3];
          in_ch.counter_select <= bus_item.sel;
          in_ch.valid          <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result against the oldest prediction and drives ready.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (verdict_q.size() == 0) begin
          mismatch_count++;
          $error("result with no item outstanding: status %0d", out_ch.status);
        end else begin
          automatic verdict_t want = verdict_q.pop_front();
          if (out_ch.status !== want.status) begin
            flag_field("status", 64'(want.status), 64'(out_ch.status));
          end
          if (out_ch.is_valid !== want.fresh) begin
            flag_field("is_valid", 64'(want.fresh), 64'(out_ch.is_valid));
          end
          if (out_ch.is_pending !== want.pending) begin
            flag_field("is_pending", 64'(want.pending), 64'(out_ch.is_pending));
          end
          if (out_ch.counter_value !== want.count) begin
            flag_field("counter_value", 64'(want.count), 64'(out_ch.counter_value));
          end
        end
      end
      if (hold_seen != hold_token) begin
        hold_seen = hold_token;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("sample_freshness_monitor: mismatch");
      $finish;
    end
  end

  initial begin
    sample_t     d;
    logic [31:0] src_val;
    logic [31:0] age_val;
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.op       = OP_PUBLISH;
    in_ch.producer_id    = '0;
    in_ch.sequence_req   = '0;
    in_ch.event_time     = '0;
    in_ch.available_time = '0;
    in_ch.now_time       = '0;
    in_ch.value_0        = '0;
    in_ch.value_1        = '0;
    in_ch.value_2        = '0;
    in_ch.value_3        = '0;
    in_ch.counter_select = '0;
    out_ch.ready   = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = CFG_EXPECTED_SOURCE;
    cfg_ch.data    = '0;
    item_on_bus    = 1'b0;
    mismatch_count = 0;
    idle_pct       = 0;
    stall_pct      = 0;
    hold_token     = 0;
    hold_seen      = 0;
    hold_left      = 0;
    quiet_cycles   = 0;
    reg_source     = EXPECTED_SOURCE_RST;
    reg_age        = MAX_AGE_RST;
    forget_all();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    write_reg(CFG_EXPECTED_SOURCE, EXPECTED_SOURCE_RST);
    write_reg(CFG_MAX_AGE, MAX_AGE_RST);

    sample_q.push_back(command(OP_READ, C_ACCEPTED, '0));
    d = publish_at(32'd5, 64'd100, 64'd200, 64'd300);
    d.vals = {32'h0000_0001, 32'h7F7F_FFFF, 32'h8000_0000, 32'h0000_0000};
    sample_q.push_back(d);
    sample_q.push_back(publish_at(32'd6, 64'd300, 64'd400, 64'd500));
    sample_q.push_back(publish_at(32'd6, 64'd500, 64'd600, 64'd700));
    sample_q.push_back(publish_at(32'd7, 64'd700, 64'd800, 64'd900));
    sample_q.push_back(command(OP_CONSUME, '0, '0));
    sample_q.push_back(command(OP_POLL, '0, 64'd800 + 64'(MAX_AGE_RST)));
    sample_q.push_back(command(OP_POLL, '0, 64'd801 + 64'(MAX_AGE_RST)));
    sample_q.push_back(command(OP_CONSUME, '0, '0));
    d = publish_at(32'd8, 64'd900, 64'd1000, 64'd1100);
    d.source = '0;
    sample_q.push_back(d);
    d = publish_at(32'd8, 64'd900, 64'd1000, 64'd1100);
    d.vals[0] = 32'h7F80_0000;
    sample_q.push_back(d);
    d = publish_at(32'd8, 64'd900, 64'd1000, 64'd1100);
    d.vals[3] = 32'h7FC0_0000;
    sample_q.push_back(d);
    d = publish_at(32'd8, 64'd900, 64'd1000, 64'd1100);
    d.vals[1] = 32'hBF80_0000;
    sample_q.push_back(d);
    sample_q.push_back(publish_at(32'd8, 64'd900, 64'd1200, 64'd1100));
    sample_q.push_back(publish_at(32'd8, 64'd1050, 64'd1000, 64'd1100));
    sample_q.push_back(publish_at(32'd8, 64'd0, 64'd1000, 64'd1001 + 64'(MAX_AGE_RST)));
    sample_q.push_back(publish_at(32'd8, 64'd0, 64'd1000, 64'd1000 + 64'(MAX_AGE_RST)));
    sample_q.push_back(command(OP_POLL, '0, 64'd999));
    sample_q.push_back(command(OP_LOSS, '0, '0));
    sample_q.push_back(command(OP_ERROR, '0, '0));
    sample_q.push_back(command(OP_TIMEOUT, '0, '0));
    sample_q.push_back(command(OP_READ, C_RECOVER, '0));
    sample_q.push_back(command(OP_READ, SEL_BEYOND, '0));
    sample_q.push_back(command(OP_CLEAR, '0, '0));
    sample_q.push_back(publish_at('1, '1, '1, '1));
    sample_q.push_back(publish_at('0, '1, '1, '1));
    wait_idle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
          src_val   = $urandom;
          age_val   = MAX_AGE_RST;
        end
        1: begin
          idle_pct  = 57;
          stall_pct = 0;
          src_val   = '0;
          age_val   = '0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 57;
          src_val   = '1;
          age_val   = '1;
        end
        default: begin
          idle_pct  = 23;
          stall_pct = 23;
          src_val   = $urandom;
          age_val   = $urandom_range(1, 5000);
        end
      endcase
      write_reg(CFG_EXPECTED_SOURCE, src_val);
      write_reg(CFG_MAX_AGE, age_val);
      if (ph == 0) write_reg(CFG_SPARE, $urandom);
      gen_seq   = $urandom;
      gen_clock = rand64() >> 1;
      // The receiver holds off while the sender keeps offering, so the queue fills.
      if (ph % 2 == 0) hold_token++;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        sample_q.push_back(random_item());
        if (n == ITEMS_PER_PHASE / 2) wait_idle();
      end
      wait_idle();
    end

    if (mismatch_count == 0 && verdict_q.size() == 0) begin
      $display("sample_freshness_monitor: match");
    end else begin
      $display("sample_freshness_monitor: mismatch");
    end
    $finish;
  end

endmodule
